/* hdl/hc_pkg.sv */
// shared types, constants and helper functions for the 3x3 mod-26 hill cipher
package hc_pkg;

    localparam int unsigned LETTER_W  = 5;
    localparam int unsigned KEY_ROW_W = 15;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned N_ENTRIES = 9;
    localparam int unsigned SLOT_W    = 4;

    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    localparam logic [1:0]          LAST_IDX   = 2'd2;

    // reset key {2,3,7; 5,7,9; 1,2,11}
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_ZERO_RST = 15'd7266;
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_ONE_RST  = 15'd9445;
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_TWO_RST  = 15'd11329;

    // register indexes on the configuration port
    localparam logic [1:0] REG_KEY_ROW_ZERO = 2'd0;
    localparam logic [1:0] REG_KEY_ROW_ONE  = 2'd1;
    localparam logic [1:0] REG_KEY_ROW_TWO  = 2'd2;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd3;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_in;
        logic                text_last;
    } hc_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_out;
        logic                block_end;
        logic                text_end;
        logic                key_error;
    } hc_out_t;

    // one operation for the shared multiply-accumulate unit
    typedef struct packed {
        logic                issue;
        logic                neg;
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
        logic [LETTER_W-1:0] acc;
    } hc_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_DET,
        ST_SCALE,
        ST_MUL,
        ST_OUT
    } hc_state_t;

    // reduce a 5-bit value below 26
    function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] v);
        red26 = (v >= MODULUS) ? v - MODULUS : v;
    endfunction

    // v mod 26 for v below 1024, reciprocal multiply is exact over this range
    function automatic logic [LETTER_W-1:0] mod26(input logic [9:0] v);
        logic [21:0] prod;
        logic [5:0]  q;
        logic [9:0]  r;
        prod  = 22'(v) * 22'd2521;
        q     = prod[21:16];
        r     = v - 10'(q) * 10'd26;
        mod26 = r[LETTER_W-1:0];
    endfunction

    // (x + 1) mod 3
    function automatic logic [1:0] inc3(input logic [1:0] x);
        inc3 = (x == LAST_IDX) ? 2'd0 : x + 2'd1;
    endfunction

    // entry c of a packed key row, reduced mod 26
    function automatic logic [LETTER_W-1:0] key_ent(input logic [KEY_ROW_W-1:0] row,
                                                   input logic [1:0] c);
        logic [LETTER_W-1:0] e;
        unique case (c)
            2'd0:    e = row[4:0];
            2'd1:    e = row[9:5];
            default: e = row[14:10];
        endcase
        key_ent = red26(e);
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] d);
        unique case (d)
            5'd1:    inv26 = 5'd1;
            5'd3:    inv26 = 5'd9;
            5'd5:    inv26 = 5'd21;
            5'd7:    inv26 = 5'd15;
            5'd9:    inv26 = 5'd3;
            5'd11:   inv26 = 5'd19;
            5'd15:   inv26 = 5'd7;
            5'd17:   inv26 = 5'd23;
            5'd19:   inv26 = 5'd11;
            5'd21:   inv26 = 5'd5;
            5'd23:   inv26 = 5'd17;
            5'd25:   inv26 = 5'd25;
            default: inv26 = 5'd0;
        endcase
    endfunction

endpackage

/* hdl/hc_mulmod.sv */
// shared multiply-accumulate unit modulo 26, result valid the cycle after issue
module hc_mulmod
    import hc_pkg::*;
(
    input  logic                aclk,
    input  hc_op_t              op,
    output logic [LETTER_W-1:0] res
);

    logic [9:0] raw_reg;
    logic [9:0] prod;

    assign prod = 10'(op.a) * 10'(op.b);

    // raw sum register, subtraction offset by 26*26 to stay positive
    always_ff @(posedge aclk) begin
        if (op.issue) begin
            if (op.neg) begin
                raw_reg <= 10'(op.acc) + 10'd676 - prod;
            end else begin
                raw_reg <= 10'(op.acc) + prod;
            end
        end
    end

    // reduce held sum
    assign res = mod26(raw_reg);

endmodule

/* hdl/hill_cipher_3x3_mod26.sv */
// top level: letter grouping, key registers, inverse builder and block multiply
// Letters are taken one per item and grouped into blocks of three; a block
// closes on its third letter or on text_last, short blocks padded with 'x'
// (23). A closing letter starts three row-times-column products on one shared
// multiply-mod-26 unit, each multiply-accumulate step having an issue phase
// and a wait phase, and each result item is held until taken. In decrypt mode
// the first block after reset or after any configuration write first builds
// the inverse key: nine cofactors, the determinant and nine scalings, on the
// same unit. The block accepts no item while a block is being worked or
// emitted. In decrypt mode a determinant not coprime with 26 gives zero
// letters with key_error set.
module hill_cipher_3x3_mod26
    import hc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input letters
    input  logic              s_valid,
    output logic              s_ready,
    input  hc_in_t            s_data,
    // result letters
    output logic              m_valid,
    input  logic              m_ready,
    output hc_out_t           m_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    hc_state_t state_reg, state_next;

    logic [KEY_ROW_W-1:0] key0_reg, key1_reg, key2_reg;
    logic                 mode_reg;
    logic                 cfg_we;

    logic [LETTER_W-1:0] pend_reg [2];
    logic [LETTER_W-1:0] pend_next [2];
    logic [1:0]          cnt_reg, cnt_next;
    logic [LETTER_W-1:0] vec_reg [3];
    logic [LETTER_W-1:0] vec_next [3];
    logic                last_reg, last_next;

    logic [LETTER_W-1:0] inv_reg [N_ENTRIES];
    logic                inv_we;
    logic [SLOT_W-1:0]   inv_waddr, inv_raddr;
    logic [LETTER_W-1:0] inv_rdata;
    logic                inv_ready_reg, inv_ready_next;
    logic [LETTER_W-1:0] dinv_reg, dinv_next;

    logic [1:0] row_reg, row_next, col_reg, col_next, k_reg, k_next;
    logic       ph_reg, ph_next;

    logic    m_valid_reg, m_valid_next;
    hc_out_t out_reg, out_next;

    hc_op_t              op;
    logic [LETTER_W-1:0] res;
    logic [SLOT_W-1:0]   slot;
    logic [1:0]          r1, r2, c1, c2;
    logic [LETTER_W-1:0] lin;
    logic                err;

    hc_mulmod u_mulmod (
        .aclk (aclk),
        .op   (op),
        .res  (res)
    );

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign cfg_we  = psel & penable & pwrite & pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= KEY_ROW_ZERO_RST;
            key1_reg <= KEY_ROW_ONE_RST;
            key2_reg <= KEY_ROW_TWO_RST;
            mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_KEY_ROW_ZERO: key0_reg <= pwdata[KEY_ROW_W-1:0];
                REG_KEY_ROW_ONE:  key1_reg <= pwdata[KEY_ROW_W-1:0];
                REG_KEY_ROW_TWO:  key2_reg <= pwdata[KEY_ROW_W-1:0];
                REG_DECRYPT_MODE: mode_reg <= pwdata[0];
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_KEY_ROW_ZERO: prdata = DATA_W'(key0_reg);
            REG_KEY_ROW_ONE:  prdata = DATA_W'(key1_reg);
            REG_KEY_ROW_TWO:  prdata = DATA_W'(key2_reg);
            REG_DECRYPT_MODE: prdata = DATA_W'(mode_reg);
        endcase
    end

    // key entry lookup by row and column
    function automatic logic [LETTER_W-1:0] key_at(input logic [1:0] r, input logic [1:0] c,
                                                   input logic [KEY_ROW_W-1:0] k0,
                                                   input logic [KEY_ROW_W-1:0] k1,
                                                   input logic [KEY_ROW_W-1:0] k2);
        logic [KEY_ROW_W-1:0] row;
        unique case (r)
            2'd0:    row = k0;
            2'd1:    row = k1;
            default: row = k2;
        endcase
        key_at = key_ent(row, c);
    endfunction

    // inverse matrix store
    always_ff @(posedge aclk) begin
        if (inv_we) begin
            inv_reg[inv_waddr] <= res;
        end
    end
    assign inv_rdata = inv_reg[inv_raddr];

    assign slot = SLOT_W'(row_reg) * SLOT_W'(3) + SLOT_W'(col_reg);
    assign r1   = inc3(col_reg);
    assign r2   = inc3(r1);
    assign c1   = inc3(row_reg);
    assign c2   = inc3(c1);
    assign lin  = red26(s_data.letter_in);
    assign err  = mode_reg && (dinv_reg == '0);

    // sequencer state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            inv_ready_reg <= 1'b0;
            dinv_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            ph_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            inv_ready_reg <= cfg_we ? 1'b0 : inv_ready_next;
            dinv_reg      <= dinv_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            k_reg         <= k_next;
            ph_reg        <= ph_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        vec_reg  <= vec_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    // next state, unit operations and register updates
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        vec_next       = vec_reg;
        last_next      = last_reg;
        inv_ready_next = inv_ready_reg;
        dinv_next      = dinv_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        k_next         = k_reg;
        ph_next        = ph_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        op             = '0;
        inv_we         = 1'b0;
        inv_waddr      = slot;
        inv_raddr      = slot;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_data.text_last && cnt_reg < LAST_IDX) begin
                        pend_next[cnt_reg[0]] = lin;
                        cnt_next = cnt_reg + 2'd1;
                    end else begin
                        vec_next[0] = (cnt_reg == 2'd0) ? lin : pend_reg[0];
                        vec_next[1] = (cnt_reg == 2'd0) ? PAD_LETTER :
                                      (cnt_reg == 2'd1) ? lin : pend_reg[1];
                        vec_next[2] = (cnt_reg == LAST_IDX) ? lin : PAD_LETTER;
                        last_next   = s_data.text_last;
                        cnt_next    = '0;
                        row_next    = '0;
                        col_next    = '0;
                        k_next      = '0;
                        ph_next     = 1'b0;
                        state_next  = (mode_reg && !inv_ready_reg) ? ST_COF : ST_MUL;
                    end
                end
            end

            // cofactor of (col,row) into slot row*3+col: two steps
            ST_COF: begin
                if (!ph_reg) begin
                    op.issue = 1'b1;
                    if (k_reg == 2'd0) begin
                        op.a = key_at(r1, c1, key0_reg, key1_reg, key2_reg);
                        op.b = key_at(r2, c2, key0_reg, key1_reg, key2_reg);
                    end else begin
                        op.a   = key_at(r1, c2, key0_reg, key1_reg, key2_reg);
                        op.b   = key_at(r2, c1, key0_reg, key1_reg, key2_reg);
                        op.neg = 1'b1;
                        op.acc = res;
                    end
                    ph_next = 1'b1;
                end else begin
                    ph_next = 1'b0;
                    if (k_reg == 2'd0) begin
                        k_next = 2'd1;
                    end else begin
                        k_next = '0;
                        inv_we = 1'b1;
                        if (col_reg == LAST_IDX) begin
                            col_next = '0;
                            if (row_reg == LAST_IDX) begin
                                row_next   = '0;
                                state_next = ST_DET;
                            end else begin
                                row_next = row_reg + 2'd1;
                            end
                        end else begin
                            col_next = col_reg + 2'd1;
                        end
                    end
                end
            end

            // determinant along row zero, cofactors of row zero sit in column zero
            ST_DET: begin
                inv_raddr = SLOT_W'(k_reg) * SLOT_W'(3);
                if (!ph_reg) begin
                    op.issue = 1'b1;
                    op.a     = key_at(2'd0, k_reg, key0_reg, key1_reg, key2_reg);
                    op.b     = inv_rdata;
                    op.acc   = (k_reg == 2'd0) ? '0 : res;
                    ph_next  = 1'b1;
                end else begin
                    ph_next = 1'b0;
                    if (k_reg == LAST_IDX) begin
                        k_next     = '0;
                        dinv_next  = inv26(res);
                        state_next = ST_SCALE;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            // scale adjugate by inverse determinant, zero factor zeroes all
            ST_SCALE: begin
                if (!ph_reg) begin
                    op.issue = 1'b1;
                    op.a     = dinv_reg;
                    op.b     = inv_rdata;
                    ph_next  = 1'b1;
                end else begin
                    ph_next = 1'b0;
                    inv_we  = 1'b1;
                    if (col_reg == LAST_IDX) begin
                        col_next = '0;
                        if (row_reg == LAST_IDX) begin
                            row_next       = '0;
                            inv_ready_next = 1'b1;
                            state_next     = ST_MUL;
                        end else begin
                            row_next = row_reg + 2'd1;
                        end
                    end else begin
                        col_next = col_reg + 2'd1;
                    end
                end
            end

            // output column col: sum over k of vec[k] * m[k][col]
            ST_MUL: begin
                inv_raddr = SLOT_W'(k_reg) * SLOT_W'(3) + SLOT_W'(col_reg);
                if (!ph_reg) begin
                    op.issue = 1'b1;
                    op.a     = vec_reg[k_reg];
                    op.b     = mode_reg ? inv_rdata :
                               key_at(k_reg, col_reg, key0_reg, key1_reg, key2_reg);
                    op.acc   = (k_reg == 2'd0) ? '0 : res;
                    ph_next  = 1'b1;
                end else begin
                    ph_next = 1'b0;
                    if (k_reg == LAST_IDX) begin
                        k_next              = '0;
                        out_next.letter_out = err ? '0 : res;
                        out_next.block_end  = (col_reg == LAST_IDX);
                        out_next.text_end   = last_reg && (col_reg == LAST_IDX);
                        out_next.key_error  = err;
                        m_valid_next        = 1'b1;
                        state_next          = ST_OUT;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            // hold result item until taken
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (col_reg == LAST_IDX) begin
                        col_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        col_next   = col_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/hc_checker.sv */
// port-level checks for the hill cipher, bound to the top level
module hc_checker
    import hc_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input hc_out_t m_data
);

    // stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // letters stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.letter_out < MODULUS)
        else $error("letter_out out of range");

    // key error forces zero letters
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.key_error |-> m_data.letter_out == '0)
        else $error("letter_out nonzero with key_error");

    // text end only on a block end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.text_end |-> m_data.block_end)
        else $error("text_end without block_end");

    // no input item taken while a result item waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

endmodule

bind hill_cipher_3x3_mod26 hc_checker u_hc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
